### hdl/assert_macros.svh
// assertion helpers for the scaler blocks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### hdl/biu_pkg.sv
`timescale 1ns / 1ps
package biu_pkg;
  localparam int unsigned FRAC_W = 9;
  localparam logic [7:0] ALPHA = 8'hFF;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;
  localparam logic CFG_OUT_WIDTH = 1'b0;
  localparam logic CFG_OUT_HEIGHT = 1'b1;

  // one channel blend a + floor((b-a)*f/256), f in 0..256
  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [8:0] f);
    logic signed [9:0] d;
    logic signed [19:0] p;
    logic signed [19:0] s;
    begin
      d = $signed({2'b00, b}) - $signed({2'b00, a});
      p = d * $signed({1'b0, f});
      s = p >>> 8;
      blend = 8'(s + $signed({12'd0, a}));
    end
  endfunction
endpackage

### hdl/biu_ram.sv
`timescale 1ns / 1ps
module biu_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

### hdl/biu_locate.sv
`timescale 1ns / 1ps
// pipelined coordinate mapper: q = c*(src-1)*256/div, restoring divide one bit per stage
module biu_locate import biu_pkg::*; #(
  parameter int unsigned SRC = 384,
  parameter int unsigned CW = 12,
  parameter int unsigned DW = 13,
  parameter int unsigned PW = $clog2(SRC)
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [CW-1:0]            coord,
  input  logic [DW-1:0]            div,
  output logic [$clog2(SRC)-1:0]   idx,
  output logic [FRAC_W-1:0]        frac
);
  localparam int unsigned SW = PW;
  localparam int unsigned NW = CW + SW + 8;
  localparam int unsigned IW = $clog2(SRC);
  localparam logic [SW-1:0] SM1 = SW'(SRC - 1);

  logic [NW-1:0] num_q;
  logic [DW-1:0] div_q;
  logic [NW-1:0] quo [1:NW];
  logic [DW:0]   rem [1:NW];
  logic [NW-1:0] nrm [1:NW];
  logic [DW-1:0] dv  [1:NW];

  always_ff @(posedge clk) begin
    if (en) begin
      num_q <= {(CW+SW)'(coord) * (CW+SW)'(SM1), 8'd0};
      div_q <= div;
    end
  end

  for (genvar s = 0; s < NW; s++) begin : g_div
    logic [NW-1:0] qi;
    logic [NW-1:0] ni;
    logic [DW:0]   ri;
    logic [DW-1:0] di;
    logic [DW+1:0] t;
    logic [NW-1:0] qn;
    logic [DW:0]   rn;
    if (s == 0) begin : g_first
      assign qi = '0;
      assign ri = '0;
      assign ni = num_q;
      assign di = div_q;
    end else begin : g_next
      assign qi = quo[s];
      assign ri = rem[s];
      assign ni = nrm[s];
      assign di = dv[s];
    end
    always_comb begin
      t = {ri, ni[NW-1]};
      if (t >= {2'b00, di}) begin
        rn = (DW+1)'(t - {2'b00, di});
        qn = {qi[NW-2:0], 1'b1};
      end else begin
        rn = t[DW:0];
        qn = {qi[NW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        quo[s+1] <= qn;
        rem[s+1] <= rn;
        nrm[s+1] <= {ni[NW-2:0], 1'b0};
        dv[s+1]  <= di;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (quo[NW][NW-1:8] > (NW-8)'(SRC - 2)) begin
        idx  <= IW'(SRC - 2);
        frac <= FRAC_W'(256);
      end else begin
        idx  <= quo[NW][8 +: IW];
        frac <= {1'b0, quo[NW][7:0]};
      end
    end
  end
endmodule

### hdl/bilinear_image_upscaler.sv
`timescale 1ns / 1ps
// bilinear rgb888 upscaler. a load transaction writes one source pixel into
// one of four banked memories (split by column and row parity) so the four
// neighbors of a sample come out of one read. a sample goes through two
// pipelined dividers (one quotient bit per stage, 29 stages at the default
// source size: 12 coordinate bits, 9 index bits and 8 fraction bits) that
// find its source position, then a clamp register, the bank read and two
// blend registers. loads ride the same number of stages before they write,
// so a sample sees exactly the loads accepted ahead of it. one transaction
// is accepted per cycle while the input is not stalled. results wait in a
// 32-entry queue; the input stalls, and the whole pipe holds, only while all
// 32 entries are full. sizes of 0 act as 1 and sizes above MAX_OUT_DIM
// saturate. reads of never-loaded pixels give undefined data.
`include "assert_macros.svh"
module bilinear_image_upscaler import biu_pkg::*; #(
  parameter int unsigned SRC_WIDTH = 384,
  parameter int unsigned SRC_HEIGHT = 288,
  parameter int unsigned MAX_OUT_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [8:0]  src_col,
  input  logic [8:0]  src_row,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [11:0] out_col,
  input  logic [11:0] out_row,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pixel_argb
);
  localparam int unsigned XW = $clog2(SRC_WIDTH);
  localparam int unsigned YW = $clog2(SRC_HEIGHT);
  // both locators use the wider index so their pipes line up
  localparam int unsigned PW = (XW > YW) ? XW : YW;
  localparam int unsigned BW = (SRC_WIDTH + 1) / 2;
  localparam int unsigned BH = (SRC_HEIGHT + 1) / 2;
  localparam int unsigned BD = BW * BH;
  localparam int unsigned AW = $clog2(BD);
  localparam int unsigned QD = 32;
  localparam int unsigned QA = $clog2(QD);
  // registers from acceptance until the locators present a position
  localparam int unsigned LL = 12 + PW + 8 + 2;

  // configuration
  logic [12:0] out_width, out_height;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_width  <= 13'd384;
      out_height <= 13'd288;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OUT_WIDTH:  out_width  <= cfg_data;
        CFG_OUT_HEIGHT: out_height <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [12:0] divof(input logic [12:0] r);
    logic [14:0] s;
    begin
      s = ({2'b00, r} > 15'(MAX_OUT_DIM)) ? 15'(MAX_OUT_DIM) : {2'b00, r};
      divof = (s > 15'd1) ? 13'(s - 15'd1) : 13'd1;
    end
  endfunction

  // pipe advances unless the queue is full
  logic [QA:0] q_cnt;
  logic        en, acc;
  assign en = (q_cnt < (QA+1)'(QD));
  assign in_stall = !en;
  assign acc = in_valid && en;

  // load path: delayed so writes reach the banks in order with sample reads
  logic ld;
  assign ld = acc && kind == KIND_LOAD && 32'(src_col) < SRC_WIDTH &&
              32'(src_row) < SRC_HEIGHT;
  logic [LL-1:0] lv;
  logic [8:0]    lcd [LL];
  logic [8:0]    lrd [LL];
  logic [23:0]   lpd [LL];
  always_ff @(posedge clk) begin
    if (rst) lv <= '0;
    else if (en) lv <= {lv[LL-2:0], ld};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      lcd[0] <= src_col;
      lrd[0] <= src_row;
      lpd[0] <= {red_in, green_in, blue_in};
      for (int k = 1; k < LL; k++) begin
        lcd[k] <= lcd[k-1];
        lrd[k] <= lrd[k-1];
        lpd[k] <= lpd[k-1];
      end
    end
  end
  logic [8:0] lc, lr;
  assign lc = lcd[LL-1];
  assign lr = lrd[LL-1];

  // sample valid shift line matching locator latency
  logic [LL-1:0] sv;
  always_ff @(posedge clk) begin
    if (rst) sv <= '0;
    else if (en) sv <= {sv[LL-2:0], acc && kind == KIND_SAMPLE};
  end

  logic [XW-1:0] xi; logic [8:0] fx;
  logic [YW-1:0] yi; logic [8:0] fy;
  biu_locate #(.SRC(SRC_WIDTH), .CW(12), .DW(13), .PW(PW)) u_lx (
    .clk, .en, .coord(out_col), .div(divof(out_width)), .idx(xi), .frac(fx));
  biu_locate #(.SRC(SRC_HEIGHT), .CW(12), .DW(13), .PW(PW)) u_ly (
    .clk, .en, .coord(out_row), .div(divof(out_height)), .idx(yi), .frac(fy));

  // banked reads: bank (col parity, row parity)
  logic [XW-1:0] x1; logic [YW-1:0] y1;
  assign x1 = xi + 1'b1;
  assign y1 = yi + 1'b1;
  logic [23:0] rd [4];
  logic [8:0] fx_r, fy_r; logic xp, yp;
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [AW-1:0] wa, ra;
    logic [XW-1:0] cx; logic [YW-1:0] cy;
    always_comb begin
      cx = ((b & 1) != 0) ? (xi[0] ? xi : x1) : (xi[0] ? x1 : xi);
      cy = ((b & 2) != 0) ? (yi[0] ? yi : y1) : (yi[0] ? y1 : yi);
      ra = AW'(32'(cy >> 1) * BW + 32'(cx >> 1));
      wa = AW'(32'(lr >> 1) * BW + 32'(lc >> 1));
    end
    biu_ram #(.WIDTH(24), .DEPTH(BD)) u_ram (
      .clk,
      .we(en && lv[LL-1] && lc[0] == ((b & 1) != 0) && lr[0] == ((b & 2) != 0)),
      .waddr(wa), .wdata(lpd[LL-1]),
      .re(en), .raddr(ra), .rdata(rd[b]));
  end
  always_ff @(posedge clk) if (en) begin
    fx_r <= fx; fy_r <= fy; xp <= xi[0]; yp <= yi[0];
  end

  // horizontal then vertical blend
  logic [23:0] p00, p10, p01, p11;
  always_comb begin
    p00 = rd[{yp, xp}]; p10 = rd[{yp, !xp}];
    p01 = rd[{!yp, xp}]; p11 = rd[{!yp, !xp}];
  end
  logic [23:0] t0, t1; logic [8:0] fy2;
  always_ff @(posedge clk) if (en) begin
    fy2 <= fy_r;
    for (int c = 0; c < 3; c++) begin
      t0[c*8 +: 8] <= blend(p00[c*8 +: 8], p10[c*8 +: 8], fx_r);
      t1[c*8 +: 8] <= blend(p01[c*8 +: 8], p11[c*8 +: 8], fx_r);
    end
  end
  logic [23:0] v;
  always_comb for (int c = 0; c < 3; c++) v[c*8 +: 8] = blend(t0[c*8 +: 8], t1[c*8 +: 8], fy2);

  // valid alignment for ram read and blend stages
  logic s1, s2, s3;
  always_ff @(posedge clk) begin
    if (rst) begin s1 <= 1'b0; s2 <= 1'b0; s3 <= 1'b0; end
    else if (en) begin s1 <= sv[LL-1]; s2 <= s1; s3 <= s2; end
  end
  logic [23:0] v_r;
  always_ff @(posedge clk) if (en) v_r <= v;

  // result queue
  logic [23:0] qm [QD];
  logic [QA-1:0] wp, rp;
  logic push, pop;
  assign push = en && s3;
  assign out_valid = q_cnt != '0;
  assign pop = out_valid && !out_stall;
  assign pixel_argb = {ALPHA, qm[rp]};
  always_ff @(posedge clk) if (push) qm[wp] <= v_r;
  always_ff @(posedge clk) begin
    if (rst) begin wp <= '0; rp <= '0; q_cnt <= '0; end
    else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      q_cnt <= q_cnt + (QA+1)'(push) - (QA+1)'(pop);
    end
  end

  `ASSERT_CLK(a_q_bound, clk, rst, q_cnt <= (QA+1)'(QD))
  `ASSERT_NEXT(a_pop_cnt, clk, rst, pop && !push, q_cnt == $past(q_cnt) - 1'b1)
  `ASSERT_NEXT(a_stall_hold, clk, rst, !en && !pop, q_cnt == $past(q_cnt))
endmodule
